// ===== src/tdg_pkg.sv =====
package tdg_pkg;

   localparam int MaxTasksDefault = 16;

   localparam logic [1:0] OP_ADD_TASK  = 2'd0;
   localparam logic [1:0] OP_ADD_EDGE  = 2'd1;
   localparam logic [1:0] OP_QUERY     = 2'd2;
   localparam logic [1:0] OP_ORDER     = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EXISTS    = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_CYCLE     = 2'd3;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [3:0]  node_a;
      logic [3:0]  node_b;
      logic [15:0] completed_mask;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] ready_mask;
      logic [3:0]  order_node;
      logic        order_valid;
      logic        last;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_WALK,
      S_ORDER,
      S_RESPOND
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;        // capture request
      logic task_commit; // commit task add
      logic walk_init;   // seed reachability walk
      logic walk_step;   // one walk expansion
      logic add_edge;    // commit edge add
      logic ord_init;    // seed order emission
      logic ord_step;    // emit one node
      logic emit;        // drive single result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] op;
      logic       a_ok;
      logic       b_ok;
      logic       a_exists;
      logic       same;
      logic       walk_done;
      logic       reach;
      logic       ord_found;
      logic       ord_last;
   } stat_type;

endpackage

// ===== src/tdg_ctrl.sv =====
module tdg_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  tdg_pkg::stat_type   stat,
   output tdg_pkg::cmd_type    cmd
);

   tdg_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tdg_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tdg_pkg::S_IDLE: begin
            if (start) state_in = tdg_pkg::S_DECODE;
         end
         tdg_pkg::S_DECODE: begin
            if (stat.op == tdg_pkg::OP_ADD_EDGE && stat.a_ok && stat.b_ok && !stat.same)
               state_in = tdg_pkg::S_WALK;
            else if (stat.op == tdg_pkg::OP_ORDER)
               state_in = tdg_pkg::S_ORDER;
            else
               state_in = tdg_pkg::S_RESPOND;
         end
         tdg_pkg::S_WALK: begin
            if (stat.walk_done) state_in = tdg_pkg::S_RESPOND;
         end
         tdg_pkg::S_ORDER: begin
            // leave on the final pick so busy drops with the last result
            if (!stat.ord_found || stat.ord_last) state_in = tdg_pkg::S_IDLE;
         end
         tdg_pkg::S_RESPOND: state_in = tdg_pkg::S_IDLE;
         default: state_in = tdg_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         tdg_pkg::S_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         tdg_pkg::S_DECODE: begin
            cmd.walk_init = (stat.op == tdg_pkg::OP_ADD_EDGE);
            cmd.ord_init  = (stat.op == tdg_pkg::OP_ORDER);
         end
         tdg_pkg::S_WALK: cmd.walk_step = 1'b1;
         tdg_pkg::S_ORDER: cmd.ord_step = 1'b1;
         tdg_pkg::S_RESPOND: begin
            cmd.emit        = 1'b1;
            cmd.task_commit = (stat.op == tdg_pkg::OP_ADD_TASK);
            cmd.add_edge    = (stat.op == tdg_pkg::OP_ADD_EDGE);
         end
         default: busy = 1'b1;
      endcase
   end

endmodule

// ===== src/tdg_datapath.sv =====
module tdg_datapath #(
   parameter int MAX_TASKS = tdg_pkg::MaxTasksDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  tdg_pkg::req_type   req_data,
   input  tdg_pkg::cmd_type   cmd,
   output tdg_pkg::stat_type  stat,
   output logic               rsp_valid,
   output tdg_pkg::rsp_type   rsp_data
);

   localparam int IW  = (MAX_TASKS > 16) ? 16 : MAX_TASKS; // visible task range
   localparam int DW  = $clog2(MAX_TASKS + 1);
   localparam int IXW = $clog2(MAX_TASKS);

   logic [MAX_TASKS-1:0] present_ff;
   logic [MAX_TASKS-1:0] rows_ff [MAX_TASKS];
   logic [DW-1:0]        indeg_ff [MAX_TASKS];
   logic [MAX_TASKS-1:0] visited_ff, emitted_ff;
   logic [DW-1:0]        deg_ff [MAX_TASKS];
   tdg_pkg::req_type     req_ff;
   logic                 valid_ff;
   tdg_pkg::rsp_type     rsp_ff, rsp_in;

   logic [MAX_TASKS-1:0] grown, ready, cand, pick, a_oh, b_oh;
   logic [IXW-1:0]       pick_ix, a_ix, b_ix;
   logic                 found, ord_last;

   // indexes are only used once the node is known to be in range
   assign a_ix = IXW'(req_ff.node_a);
   assign b_ix = IXW'(req_ff.node_b);

   always_comb begin
      a_oh = '0;
      b_oh = '0;
      if (32'(req_ff.node_a) < MAX_TASKS) a_oh[req_ff.node_a] = 1'b1;
      if (32'(req_ff.node_b) < MAX_TASKS) b_oh[req_ff.node_b] = 1'b1;
   end

   // one reachability expansion per cycle
   always_comb begin
      grown = visited_ff;
      for (int i = 0; i < MAX_TASKS; i++)
         if (visited_ff[i]) grown = grown | rows_ff[i];
   end

   always_comb begin
      ready = '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
         if (present_ff[i] && !(i < 16 && req_ff.completed_mask[i % 16])) begin
            ready[i] = 1'b1;
            for (int j = 0; j < MAX_TASKS; j++)
               if (rows_ff[j][i] && !(j < 16 && req_ff.completed_mask[j % 16]))
                  ready[i] = 1'b0;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_TASKS; i++)
         cand[i] = present_ff[i] && deg_ff[i] == '0 && !emitted_ff[i];
      pick = cand & (~cand + 1'b1);
      found = |cand;
      ord_last = found && (cand & ~pick) == '0 &&
                 (present_ff & ~emitted_ff & ~pick) == '0;
      pick_ix = '0;
      for (int i = 0; i < MAX_TASKS; i++)
         if (pick[i]) pick_ix = IXW'(i);
   end

   always_comb begin
      stat.op        = req_ff.opcode;
      stat.a_ok      = |(a_oh & present_ff);
      stat.b_ok      = |(b_oh & present_ff);
      stat.a_exists  = stat.a_ok;
      stat.same      = req_ff.node_a == req_ff.node_b;
      stat.walk_done = grown == visited_ff;
      stat.reach     = |(visited_ff & a_oh);
      stat.ord_found = found;
      stat.ord_last  = ord_last;
   end

   always_ff @(posedge clock) begin
      if (reset) req_ff <= '0;
      else if (cmd.load) req_ff <= req_data;
      if (cmd.walk_init) visited_ff <= b_oh;
      else if (cmd.walk_step) visited_ff <= grown;
      if (cmd.ord_init) begin
         emitted_ff <= '0;
         for (int i = 0; i < MAX_TASKS; i++) deg_ff[i] <= indeg_ff[i];
      end else if (cmd.ord_step && found) begin
         emitted_ff <= emitted_ff | pick;
         for (int j = 0; j < MAX_TASKS; j++)
            if (rows_ff[pick_ix][j] && deg_ff[j] != '0)
               deg_ff[j] <= deg_ff[j] - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
         for (int i = 0; i < MAX_TASKS; i++) begin
            rows_ff[i]  <= '0;
            indeg_ff[i] <= '0;
         end
      end else begin
         if (cmd.task_commit && !stat.a_exists && |a_oh) begin
            present_ff     <= present_ff | a_oh;
            rows_ff[a_ix]  <= '0;
            indeg_ff[a_ix] <= '0;
         end
         if (cmd.add_edge && stat.a_ok && stat.b_ok && !stat.same && !stat.reach &&
             !rows_ff[a_ix][b_ix]) begin
            rows_ff[a_ix]  <= rows_ff[a_ix] | b_oh;
            indeg_ff[b_ix] <= indeg_ff[b_ix] + 1'b1;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= cmd.emit || (cmd.ord_step && (found || emitted_ff == '0));
   end

   always_comb begin
      rsp_in = '0;
      if (cmd.ord_step) begin
         rsp_in.order_node  = 4'(pick_ix);
         rsp_in.order_valid = found;
         rsp_in.last        = !found || ord_last;
      end else begin
         rsp_in.last = 1'b1;
         unique case (req_ff.opcode)
            tdg_pkg::OP_ADD_TASK:
               rsp_in.status = (|a_oh == 1'b0) ? tdg_pkg::ST_NOT_FOUND :
                               stat.a_exists ? tdg_pkg::ST_EXISTS : tdg_pkg::ST_OK;
            tdg_pkg::OP_ADD_EDGE:
               rsp_in.status = (!stat.a_ok || !stat.b_ok) ? tdg_pkg::ST_NOT_FOUND :
                               (stat.same || stat.reach) ? tdg_pkg::ST_CYCLE :
                               tdg_pkg::ST_OK;
            tdg_pkg::OP_QUERY: rsp_in.ready_mask = 16'(ready[IW-1:0]);
            default: rsp_in.status = tdg_pkg::ST_OK;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== src/task_dependency_graph_unit.sv =====
// Task dependency graph unit.
// Requests: req_data (opcode, node_a, node_b, completed_mask) is taken on a
// clock edge with start high and busy low. Results come on rsp_data, each
// marked by rsp_valid for one cycle; the receiver takes every result.
// Add task and query ready: one result, via the DECODE and RESPOND states
// and the result register. Add dependency: a missing end or a self edge goes
// from DECODE straight to RESPOND; otherwise the reachability walk expands the
// visited set by one hop per cycle until it stops growing, then responds.
// Topological order: after the DECODE setup step, one node is emitted per
// cycle from the emission loop (Kahn step, lowest index first); N present
// tasks give N results, the first from the first ORDER step, the last
// flagged by last; an empty graph gives one result with order_valid low.
// busy is low again in the cycle that carries the last result, so the next
// transfer can be taken there.
// Reset (synchronous) clears the task set, edges and in-degrees at once.
module task_dependency_graph_unit #(
   parameter int MAX_TASKS = tdg_pkg::MaxTasksDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tdg_pkg::req_type  req_data,
   output logic              rsp_valid,
   output tdg_pkg::rsp_type  rsp_data
);

   tdg_pkg::cmd_type  cmd;
   tdg_pkg::stat_type stat;

   tdg_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   tdg_datapath #(.MAX_TASKS(MAX_TASKS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== src/tdg_checker.sv =====
module tdg_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input tdg_pkg::rsp_type rsp_data
);

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("no busy after transfer");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |-> !busy) else $error("busy after last");

   a_order_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.order_valid |-> rsp_data.status == tdg_pkg::ST_OK &&
      rsp_data.ready_mask == '0) else $error("order result fields");

   a_no_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      !busy && !$past(busy) |-> !rsp_valid) else $error("result while idle");

endmodule

bind task_dependency_graph_unit tdg_checker u_tdg_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
